// ===== rtl/csvt_pkg.sv =====
`default_nettype none
package csvt_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned POS_W     = 40;
  localparam int unsigned LEN_W     = 23;
  localparam int unsigned CNT_W     = LEN_W + 1;  // saturating internal count
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  localparam int unsigned DEFAULT_MAX_COLUMNS = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_COLUMN = 2'd1;

  localparam logic [BYTE_W-1:0] DELIM_RESET    = 8'd44;
  localparam logic [COL_W-1:0]  LAST_COL_RESET = 10'd1023;

  // characters
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  // length limits: max reportable, and internal saturation point
  localparam logic [CNT_W-1:0] LEN_MAX = 24'd8388607;
  localparam logic [CNT_W-1:0] LEN_CAP = 24'd8388609;

  // result queue
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] column_index;
    logic [POS_W-1:0] field_offset;
    logic [LEN_W-1:0] field_length;
    logic             escaped;
    logic             too_long;
    logic             unterminated;
    logic             row_end;
    logic             last_of_run;
  } out_item_t;

  // up to two results per byte, packed toward slot 0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t res0;
    out_item_t res1;
  } push_t;

endpackage
`default_nettype wire

// ===== rtl/csvt_core.sv =====
`default_nettype none
module csvt_core #(
  parameter int unsigned MAX_COLUMNS = csvt_pkg::DEFAULT_MAX_COLUMNS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire csvt_pkg::in_item_t                 in_data,
  input  wire logic [csvt_pkg::BYTE_W-1:0]        delimiter,
  input  wire logic [csvt_pkg::COL_W-1:0]         last_column,
  input  wire logic                               room,
  output csvt_pkg::push_t                         push
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS) + 1;
  localparam int unsigned EW = (CW > csvt_pkg::COL_W) ? CW : csvt_pkg::COL_W;
  localparam logic [EW-1:0] COL_LIM = EW'(MAX_COLUMNS - 1);

  typedef enum logic [3:0] {
    PH_ROW_START   = 4'd0,
    PH_ROW_CR      = 4'd1,
    PH_FIELD_START = 4'd2,
    PH_UNQ         = 4'd3,
    PH_Q_BODY      = 4'd4,
    PH_Q_QUOTE     = 4'd5,
    PH_Q_TAIL      = 4'd6,
    PH_SKIP        = 4'd7,
    PH_SKIP_Q      = 4'd8,
    PH_SKIP_QQ     = 4'd9
  } phase_t;

  function automatic logic [csvt_pkg::CNT_W-1:0] sat_add(
    input logic [csvt_pkg::CNT_W-1:0] c,
    input logic [1:0]                 k
  );
    logic [csvt_pkg::CNT_W:0] s;
    s = {1'b0, c} + (csvt_pkg::CNT_W+1)'(k);
    if (s > {1'b0, csvt_pkg::LEN_CAP}) begin
      return csvt_pkg::LEN_CAP;
    end
    return s[csvt_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [csvt_pkg::CNT_W-1:0] unq_len(
    input logic [csvt_pkg::CNT_W-1:0] c,
    input logic                       cr
  );
    return (cr && c != '0) ? c - 1'b1 : c;
  endfunction

  function automatic csvt_pkg::out_item_t mk_res(
    input logic [CW-1:0]                col,
    input logic [csvt_pkg::POS_W-1:0]   off,
    input logic [csvt_pkg::CNT_W-1:0]   cnt,
    input logic                         esc,
    input logic                         unt,
    input logic                         row
  );
    csvt_pkg::out_item_t r;
    logic                over;
    over           = cnt > csvt_pkg::LEN_MAX;
    r.column_index = csvt_pkg::COL_W'(col);
    r.field_offset = off;
    r.field_length = over ? csvt_pkg::LEN_MAX[csvt_pkg::LEN_W-1:0]
                          : cnt[csvt_pkg::LEN_W-1:0];
    r.escaped      = esc;
    r.too_long     = over;
    r.unterminated = unt;
    r.row_end      = row;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // input holding register
  logic                  hold_v_r;
  csvt_pkg::in_item_t    hold_r;

  // parse state
  phase_t                       phase_r, phase_nxt;
  logic [csvt_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [csvt_pkg::POS_W-1:0]   fs_r, fs_nxt;
  logic [csvt_pkg::CNT_W-1:0]   lc_r, lc_nxt;
  logic [CW-1:0]                cc_r, cc_nxt;
  logic                         esc_r, esc_nxt;
  logic                         pcr_r, pcr_nxt;

  logic                  fire, accept;
  logic [EW-1:0]         last_eff;
  logic [EW-1:0]         last_ext;
  logic [csvt_pkg::BYTE_W-1:0] b;
  logic                  is_q, is_lf, is_cr, is_dl;
  logic                  do_start, do_unq, do_tail, do_row;
  logic                  s_hit, e_hit;
  csvt_pkg::out_item_t   s_res, e_res;
  logic [csvt_pkg::CNT_W-1:0] ulen;

  assign fire     = hold_v_r && room;
  assign in_stall = hold_v_r && !room;
  assign accept   = in_valid && !in_stall;

  assign last_ext = EW'(last_column);
  assign last_eff = (last_ext < COL_LIM) ? last_ext : COL_LIM;

  assign b     = hold_r.data_byte;
  assign is_q  = (b == csvt_pkg::CH_QUOTE);
  assign is_lf = (b == csvt_pkg::CH_LF);
  assign is_cr = (b == csvt_pkg::CH_CR);
  assign is_dl = (b == delimiter);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    fs_nxt    = fs_r;
    lc_nxt    = lc_r;
    cc_nxt    = cc_r;
    esc_nxt   = esc_r;
    pcr_nxt   = pcr_r;
    do_start  = 1'b0;
    do_unq    = 1'b0;
    do_tail   = 1'b0;
    do_row    = 1'b0;
    s_hit     = 1'b0;
    e_hit     = 1'b0;
    s_res     = '0;
    e_res     = '0;
    ulen      = '0;

    unique case (phase_r)
      PH_ROW_START: do_row = 1'b1;
      PH_ROW_CR: begin
        if (is_lf) begin
          phase_nxt = PH_ROW_START;
        end else begin
          do_unq = 1'b1;
        end
      end
      PH_FIELD_START: do_start = 1'b1;
      PH_UNQ:         do_unq   = 1'b1;
      PH_Q_BODY: begin
        if (is_q) begin
          phase_nxt = PH_Q_QUOTE;
        end else begin
          lc_nxt = sat_add(lc_r, 2'd1);
        end
      end
      PH_Q_QUOTE: begin
        if (is_q) begin
          lc_nxt    = sat_add(lc_r, 2'd2);
          esc_nxt   = 1'b1;
          phase_nxt = PH_Q_BODY;
        end else begin
          phase_nxt = PH_Q_TAIL;
          do_tail   = 1'b1;
        end
      end
      PH_Q_TAIL: do_tail = 1'b1;
      PH_SKIP: begin
        if (is_lf) begin
          phase_nxt = PH_ROW_START;
          cc_nxt    = '0;
        end else if (is_q) begin
          phase_nxt = PH_SKIP_Q;
        end
      end
      PH_SKIP_Q: begin
        if (is_q) begin
          phase_nxt = PH_SKIP_QQ;
        end
      end
      PH_SKIP_QQ: begin
        if (is_q) begin
          phase_nxt = PH_SKIP_Q;
        end else if (is_lf) begin
          phase_nxt = PH_ROW_START;
          cc_nxt    = '0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      default: do_row = 1'b1;
    endcase

    // row start: blank LF skipped, CR held back to catch CRLF
    if (do_row) begin
      if (is_lf) begin
        phase_nxt = PH_ROW_START;
      end else if (is_cr && delimiter != csvt_pkg::CH_CR) begin
        phase_nxt = PH_ROW_CR;
        fs_nxt    = pos_r;
        lc_nxt    = 24'd1;
        pcr_nxt   = 1'b1;
        esc_nxt   = 1'b0;
      end else begin
        do_start = 1'b1;
      end
    end

    if (do_start) begin
      esc_nxt = 1'b0;
      pcr_nxt = 1'b0;
      lc_nxt  = '0;
      if (is_q) begin
        phase_nxt = PH_Q_BODY;
        fs_nxt    = pos_r + 1'b1;
      end else if (is_lf) begin
        s_hit     = EW'(cc_r) <= last_eff;
        s_res     = mk_res(cc_r, pos_r, '0, 1'b0, 1'b0, 1'b1);
        phase_nxt = PH_ROW_START;
        cc_nxt    = '0;
      end else if (is_dl) begin
        s_hit     = EW'(cc_r) <= last_eff;
        s_res     = mk_res(cc_r, pos_r, '0, 1'b0, 1'b0, 1'b0);
        cc_nxt    = cc_r + 1'b1;
        phase_nxt = (EW'(cc_nxt) > last_eff) ? PH_SKIP : PH_FIELD_START;
      end else begin
        phase_nxt = PH_UNQ;
        fs_nxt    = pos_r;
        lc_nxt    = 24'd1;
        pcr_nxt   = is_cr;
      end
    end

    if (do_unq) begin
      ulen = unq_len(lc_r, pcr_r);
      if (is_lf) begin
        s_hit     = EW'(cc_r) <= last_eff;
        s_res     = mk_res(cc_r, fs_r, ulen, 1'b0, 1'b0, 1'b1);
        phase_nxt = PH_ROW_START;
        cc_nxt    = '0;
      end else if (is_dl) begin
        s_hit     = EW'(cc_r) <= last_eff;
        s_res     = mk_res(cc_r, fs_r, ulen, 1'b0, 1'b0, 1'b0);
        cc_nxt    = cc_r + 1'b1;
        phase_nxt = (EW'(cc_nxt) > last_eff) ? PH_SKIP : PH_FIELD_START;
      end else begin
        phase_nxt = PH_UNQ;
        lc_nxt    = sat_add(lc_r, 2'd1);
        pcr_nxt   = is_cr;
      end
    end

    // text after the closing quote is dropped
    if (do_tail) begin
      if (is_lf) begin
        s_hit     = EW'(cc_r) <= last_eff;
        s_res     = mk_res(cc_r, fs_r, lc_r, esc_r, 1'b0, 1'b1);
        phase_nxt = PH_ROW_START;
        cc_nxt    = '0;
      end else if (is_dl) begin
        s_hit     = EW'(cc_r) <= last_eff;
        s_res     = mk_res(cc_r, fs_r, lc_r, esc_r, 1'b0, 1'b0);
        cc_nxt    = cc_r + 1'b1;
        phase_nxt = (EW'(cc_nxt) > last_eff) ? PH_SKIP : PH_FIELD_START;
      end
    end

    // end of data: flush the open field, then restart the stream
    if (hold_r.end_of_data) begin
      case (phase_nxt)
        PH_FIELD_START: begin
          e_hit = EW'(cc_nxt) <= last_eff;
          e_res = mk_res(cc_nxt, pos_r + 1'b1, '0, 1'b0, 1'b0, 1'b1);
        end
        PH_ROW_CR, PH_UNQ: begin
          e_hit = EW'(cc_nxt) <= last_eff;
          e_res = mk_res(cc_nxt, fs_nxt, unq_len(lc_nxt, pcr_nxt), 1'b0, 1'b0, 1'b1);
        end
        PH_Q_BODY: begin
          e_hit = EW'(cc_nxt) <= last_eff;
          e_res = mk_res(cc_nxt, fs_nxt, lc_nxt, esc_nxt, 1'b1, 1'b1);
        end
        PH_Q_QUOTE, PH_Q_TAIL: begin
          e_hit = EW'(cc_nxt) <= last_eff;
          e_res = mk_res(cc_nxt, fs_nxt, lc_nxt, esc_nxt, 1'b0, 1'b1);
        end
        default: begin
          e_hit = 1'b0;
        end
      endcase
      phase_nxt = PH_ROW_START;
      pos_nxt   = '0;
      fs_nxt    = '0;
      lc_nxt    = '0;
      cc_nxt    = '0;
      esc_nxt   = 1'b0;
      pcr_nxt   = 1'b0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  // pack results toward slot 0 and mark the last one
  always_comb begin
    push      = '0;
    push.v0   = fire && (s_hit || e_hit);
    push.v1   = fire && s_hit && e_hit;
    push.res0 = s_hit ? s_res : e_res;
    push.res1 = e_res;
    push.res0.last_of_run = !(s_hit && e_hit);
    push.res1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      phase_r  <= PH_ROW_START;
      pos_r    <= '0;
      fs_r     <= '0;
      lc_r     <= '0;
      cc_r     <= '0;
      esc_r    <= 1'b0;
      pcr_r    <= 1'b0;
    end else begin
      if (accept) begin
        hold_v_r <= 1'b1;
      end else if (fire) begin
        hold_v_r <= 1'b0;
      end
      if (fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        fs_r    <= fs_nxt;
        lc_r    <= lc_nxt;
        cc_r    <= cc_nxt;
        esc_r   <= esc_nxt;
        pcr_r   <= pcr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csvt_outq.sv =====
`default_nettype none
module csvt_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire csvt_pkg::push_t      push,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output csvt_pkg::out_item_t       out_data
);

  csvt_pkg::out_item_t                mem [csvt_pkg::OUTQ_DEPTH];
  logic [csvt_pkg::OUTQ_AW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [csvt_pkg::OUTQ_CW-1:0]       cnt_r, cnt_nxt;
  logic                               pop;
  logic [csvt_pkg::OUTQ_AW-1:0]       wr_ptr_p1;

  assign out_valid = cnt_r != '0;
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // two free slots needed so a byte ending two fields always fits
  assign room      = cnt_r <= csvt_pkg::OUTQ_CW'(csvt_pkg::OUTQ_DEPTH - 2);
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r + csvt_pkg::OUTQ_CW'(push.v0) + csvt_pkg::OUTQ_CW'(push.v1)
              - csvt_pkg::OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push.v1) begin
        wr_ptr_r <= wr_ptr_r + 2'd2;
      end else if (push.v0) begin
        wr_ptr_r <= wr_ptr_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.v1) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/csv_field_tokenizer.sv =====
`default_nettype none
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | in_data: data_byte, end_of_data
// out_    | out | out_valid/out_stall| out_data: one field descriptor per request
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (delimiter, last_column)
//
// One byte per cycle sustained while the queue has room. An accepted byte is held
// in the input register until the queue has room, then the parse step writes its
// results into a 4-entry result queue, from which the first result shows on out_.
// A byte that ends two fields pushes two results; a held byte stalls in_ while the
// queue has fewer than two free slots, so a slow consumer backs up into the input.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// cfg_ready is always high; writes are registered.
module csv_field_tokenizer #(
  parameter int unsigned MAX_COLUMNS = csvt_pkg::DEFAULT_MAX_COLUMNS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // byte input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire csvt_pkg::in_item_t                  in_data,
  // field descriptors
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output csvt_pkg::out_item_t                      out_data,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [csvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [csvt_pkg::CFG_DAT_W-1:0]      cfg_data
);

  logic [csvt_pkg::BYTE_W-1:0] delimiter_r;
  logic [csvt_pkg::COL_W-1:0]  last_column_r;
  logic                        room;
  csvt_pkg::push_t             push;

  assign cfg_ready = 1'b1;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r   <= csvt_pkg::DELIM_RESET;
      last_column_r <= csvt_pkg::LAST_COL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csvt_pkg::CFG_DELIMITER:   delimiter_r   <= cfg_data[csvt_pkg::BYTE_W-1:0];
        csvt_pkg::CFG_LAST_COLUMN: last_column_r <= cfg_data[csvt_pkg::COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // parse step: input register, state, up to two results per byte
  csvt_core #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .delimiter  (delimiter_r),
    .last_column(last_column_r),
    .room       (room),
    .push       (push)
  );

  // result queue decouples the parser from the consumer
  csvt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
